/* hdl/dtc_pkg.sv */
// ----------------------------------------------------------------------------
// dtc_pkg
// shared types and codes for the detection track confirmation block
// ----------------------------------------------------------------------------
package dtc_pkg;

  // result status codes
  localparam logic [1:0] ST_REJECT  = 2'd0;
  localparam logic [1:0] ST_TRACK   = 2'd1;
  localparam logic [1:0] ST_CONFIRM = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // request function codes
  localparam logic FN_BOX = 1'b0;
  localparam logic FN_EOF = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_W   = 3'd0;
  localparam logic [2:0] REG_MAX_W   = 3'd1;
  localparam logic [2:0] REG_MIN_H   = 3'd2;
  localparam logic [2:0] REG_MAX_H   = 3'd3;
  localparam logic [2:0] REG_RADIUS  = 3'd4;
  localparam logic [2:0] REG_CONFIRM = 3'd5;

  localparam int CFG_BITS = 12;
  localparam int CNT_BITS = 6;

  // control bits of the search token travelling down the cell row
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctrl_t;

  // controller state
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

/* hdl/detection_track_confirm.sv */
// ----------------------------------------------------------------------------
// detection_track_confirm
// nearest previous-box association with consecutive-frame hit count
// ----------------------------------------------------------------------------
// A box request is taken when start is high and busy is low. A box that
// fails the size limits gives its result in the next cycle and leaves busy
// low. Any other box sends a search token down a row of MAX_BOXES cells, one
// cell per cycle, behind a launch register and ahead of the output register,
// and busy stays high until its result strobe. An end of frame request
// leaves busy low and gives no result. out_valid is high for exactly one
// cycle per result; the receiver must take it then.
module detection_track_confirm #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [COORD_BITS-1:0] in_box_x,
  input  logic [COORD_BITS-1:0] in_box_y,
  input  logic [COORD_BITS-1:0] in_box_w,
  input  logic [COORD_BITS-1:0] in_box_h,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [5:0]            out_track_count,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [COORD_BITS-1:0] out_w,
  output logic [COORD_BITS-1:0] out_h,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import dtc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = CB + 2;
  localparam int DW = (2*CB+5 > 2*CFG_BITS+2) ? 2*CB+5 : 2*CFG_BITS+2;
  localparam int MW = (CB > CFG_BITS) ? CB : CFG_BITS;
  localparam int FW = $clog2(MAX_BOXES + 1);
  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int N  = MAX_BOXES;

  // configuration registers
  logic [CFG_BITS-1:0] min_w_r, max_w_r, min_h_r, max_h_r, radius_r;
  logic [CNT_BITS-1:0] confirm_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_w_r   <= CFG_BITS'(10);
      max_w_r   <= CFG_BITS'(150);
      min_h_r   <= CFG_BITS'(10);
      max_h_r   <= CFG_BITS'(150);
      radius_r  <= CFG_BITS'(50);
      confirm_r <= CNT_BITS'(5);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MIN_W:   min_w_r   <= pwdata[CFG_BITS-1:0];
        REG_MAX_W:   max_w_r   <= pwdata[CFG_BITS-1:0];
        REG_MIN_H:   min_h_r   <= pwdata[CFG_BITS-1:0];
        REG_MAX_H:   max_h_r   <= pwdata[CFG_BITS-1:0];
        REG_RADIUS:  radius_r  <= pwdata[CFG_BITS-1:0];
        REG_CONFIRM: confirm_r <= pwdata[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      REG_MIN_W:   prdata = 32'(min_w_r);
      REG_MAX_W:   prdata = 32'(max_w_r);
      REG_MIN_H:   prdata = 32'(min_h_r);
      REG_MAX_H:   prdata = 32'(max_h_r);
      REG_RADIUS:  prdata = 32'(radius_r);
      REG_CONFIRM: prdata = 32'(confirm_r);
      default:     prdata = 32'd0;
    endcase
  end

  // request decode and size check
  state_t         state_r, state_nxt;
  logic           accept, is_box, size_ok;
  logic [FW-1:0]  prev_fill_r, cur_fill_r;

  assign busy   = (state_r == S_SCAN);
  assign accept = start && !busy;
  assign is_box = (in_func == FN_BOX);
  assign size_ok = !(MW'(in_box_w) > MW'(max_w_r) || MW'(in_box_w) < MW'(min_w_r) ||
                     MW'(in_box_h) > MW'(max_h_r) || MW'(in_box_h) < MW'(min_h_r));

  // cell row wiring, index N is the end of the row
  tok_ctrl_t           ctrl   [0:N];
  logic [CW-1:0]       cx     [0:N];
  logic [CW-1:0]       cy     [0:N];
  logic [DW-1:0]       best   [0:N];
  logic [CNT_BITS-1:0] cnt    [0:N];
  logic [N-1:0]        cmp_en, wr_en;

  logic                launch_r;
  logic [CW-1:0]       q_cx_r, q_cy_r;
  logic [DW-1:0]       q_best_r;
  logic [CB-1:0]       q_x_r, q_y_r, q_w_r, q_h_r;
  logic                swap, fin, full;
  logic [CNT_BITS-1:0] cap, new_cnt;

  assign swap = accept && !is_box;
  assign fin  = ctrl[N].valid;
  assign full = (cur_fill_r == FW'(MAX_BOXES));

  // query registers loaded with the request
  always_ff @(posedge clk) begin
    if (accept && is_box) begin
      q_x_r    <= in_box_x;
      q_y_r    <= in_box_y;
      q_w_r    <= in_box_w;
      q_h_r    <= in_box_h;
      q_cx_r   <= (CW'(in_box_x) << 1) + CW'(in_box_w);
      q_cy_r   <= (CW'(in_box_y) << 1) + CW'(in_box_h);
      q_best_r <= DW'({radius_r, 1'b0} * {radius_r, 1'b0});
    end
  end

  // token entry at the head of the row
  assign ctrl[0] = '{valid: launch_r, found: 1'b0};
  assign cx[0]   = q_cx_r;
  assign cy[0]   = q_cy_r;
  assign best[0] = q_best_r;
  assign cnt[0]  = '0;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      assign cmp_en[gi] = (FW'(gi) < prev_fill_r);
      assign wr_en[gi]  = fin && !full && (cur_fill_r[IW-1:0] == IW'(gi));
      dtc_cell #(.CW(CW), .DW(DW)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl_i (ctrl[gi]),
        .cx_i   (cx[gi]),
        .cy_i   (cy[gi]),
        .best_i (best[gi]),
        .cnt_i  (cnt[gi]),
        .cmp_en (cmp_en[gi]),
        .swap   (swap),
        .wr_en  (wr_en[gi]),
        .wr_cx  (q_cx_r),
        .wr_cy  (q_cy_r),
        .wr_cnt (new_cnt),
        .ctrl_o (ctrl[gi+1]),
        .cx_o   (cx[gi+1]),
        .cy_o   (cy[gi+1]),
        .best_o (best[gi+1]),
        .cnt_o  (cnt[gi+1])
      );
    end
  endgenerate

  // updated count with ceiling at confirm plus one, or at 63 when confirm is 63
  always_comb begin
    cap = (confirm_r == '1) ? confirm_r : confirm_r + CNT_BITS'(1);
    if (!ctrl[N].found) begin
      new_cnt = '0;
    end else if (cnt[N] >= cap) begin
      new_cnt = cap;
    end else begin
      new_cnt = cnt[N] + CNT_BITS'(1);
    end
  end

  // controller
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && is_box && size_ok) state_nxt = S_SCAN;
      S_SCAN: if (fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      prev_fill_r <= '0;
      cur_fill_r  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      launch_r  <= accept && is_box && size_ok;
      out_valid <= (accept && is_box && !size_ok) || fin;
      if (swap) begin
        prev_fill_r <= cur_fill_r;
        cur_fill_r  <= '0;
      end else if (fin && !full) begin
        cur_fill_r <= cur_fill_r + FW'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && is_box && !size_ok) begin
      out_status      <= ST_REJECT;
      out_track_count <= '0;
      out_x           <= in_box_x;
      out_y           <= in_box_y;
      out_w           <= in_box_w;
      out_h           <= in_box_h;
    end else if (fin) begin
      if (full) begin
        out_status <= ST_FULL;
      end else if (new_cnt == confirm_r) begin
        out_status <= ST_CONFIRM;
      end else begin
        out_status <= ST_TRACK;
      end
      out_track_count <= new_cnt;
      out_x           <= q_x_r;
      out_y           <= q_y_r;
      out_w           <= q_w_r;
      out_h           <= q_h_r;
    end
  end

endmodule

/* hdl/dtc_cell.sv */
// ----------------------------------------------------------------------------
// dtc_cell
// one table slot: holds a previous-frame and a current-frame entry and
// compares the passing search token against the previous entry
// ----------------------------------------------------------------------------
module dtc_cell #(
  parameter int CW = 14,
  parameter int DW = 29
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dtc_pkg::tok_ctrl_t         ctrl_i,
  input  logic [CW-1:0]              cx_i,
  input  logic [CW-1:0]              cy_i,
  input  logic [DW-1:0]              best_i,
  input  logic [dtc_pkg::CNT_BITS-1:0] cnt_i,
  input  logic                       cmp_en,
  input  logic                       swap,
  input  logic                       wr_en,
  input  logic [CW-1:0]              wr_cx,
  input  logic [CW-1:0]              wr_cy,
  input  logic [dtc_pkg::CNT_BITS-1:0] wr_cnt,
  output dtc_pkg::tok_ctrl_t         ctrl_o,
  output logic [CW-1:0]              cx_o,
  output logic [CW-1:0]              cy_o,
  output logic [DW-1:0]              best_o,
  output logic [dtc_pkg::CNT_BITS-1:0] cnt_o
);
  import dtc_pkg::*;

  logic [CW-1:0]       prev_cx_r, prev_cy_r, cur_cx_r, cur_cy_r;
  logic [CNT_BITS-1:0] prev_cnt_r, cur_cnt_r;
  tok_ctrl_t           ctrl_r;
  logic [CW-1:0]       cx_r, cy_r;
  logic [DW-1:0]       best_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [CW-1:0]       dx, dy;
  logic [2*CW:0]       dsq;
  logic                hit;

  // entry storage, current moves to previous at end of frame
  always_ff @(posedge clk) begin
    if (swap) begin
      prev_cx_r  <= cur_cx_r;
      prev_cy_r  <= cur_cy_r;
      prev_cnt_r <= cur_cnt_r;
    end
    if (wr_en) begin
      cur_cx_r  <= wr_cx;
      cur_cy_r  <= wr_cy;
      cur_cnt_r <= wr_cnt;
    end
  end

  // squared doubled-center distance to the stored entry
  always_comb begin
    dx   = (prev_cx_r > cx_i) ? prev_cx_r - cx_i : cx_i - prev_cx_r;
    dy   = (prev_cy_r > cy_i) ? prev_cy_r - cy_i : cy_i - prev_cy_r;
    dsq  = (2*CW+1)'(dx * dx) + (2*CW+1)'(dy * dy);
    hit  = ctrl_i.valid && cmp_en && (DW'(dsq) < best_i);
  end

  // token control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r.valid <= ctrl_i.valid;
      ctrl_r.found <= ctrl_i.found | hit;
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    cx_r   <= cx_i;
    cy_r   <= cy_i;
    best_r <= hit ? DW'(dsq) : best_i;
    cnt_r  <= hit ? prev_cnt_r : cnt_i;
  end

  assign ctrl_o = ctrl_r;
  assign cx_o   = cx_r;
  assign cy_o   = cy_r;
  assign best_o = best_r;
  assign cnt_o  = cnt_r;

endmodule

/* test/dtc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtc_checker
// watches the request and result ports of the track confirmation block,
// predicts each result from its own copy of the box tables and registers,
// and compares field by field in order
// ----------------------------------------------------------------------------
module dtc_checker
  import dtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_func,
  input  logic [11:0] in_box_x,
  input  logic [11:0] in_box_y,
  input  logic [11:0] in_box_w,
  input  logic [11:0] in_box_h,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [5:0]  out_track_count,
  input  logic [11:0] out_x,
  input  logic [11:0] out_y,
  input  logic [11:0] out_w,
  input  logic [11:0] out_h,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          confirms_seen,
  output int          full_seen
);

  typedef struct packed {
    logic [11:0] x, y, w, h;
    logic [5:0]  cnt;
  } track_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  cnt;
    logic [11:0] x, y, w, h;
  } verdict_t;

  track_t   prev_tab [64];
  track_t   cur_tab  [64];
  int       prev_fill, cur_fill;
  logic [11:0] lim_min_w, lim_max_w, lim_min_h, lim_max_h, radius;
  logic [5:0]  confirm_at;
  verdict_t exp_q [$];

  // work out the result of one box and update the current table
  function automatic verdict_t track_box(logic [11:0] x, y, w, h);
    verdict_t v;
    longint cx, cy, best, dx, dy, d;
    int idx;
    bit hit;
    int cap, c;
    v.x = x; v.y = y; v.w = w; v.h = h;
    if (w > lim_max_w || w < lim_min_w || h > lim_max_h || h < lim_min_h) begin
      v.status = ST_REJECT;
      v.cnt = 0;
      return v;
    end
    cx = 2 * longint'(x) + w;
    cy = 2 * longint'(y) + h;
    best = 4 * longint'(radius) * radius;
    hit = 0;
    idx = 0;
    for (int i = 0; i < prev_fill; i++) begin
      dx = 2 * longint'(prev_tab[i].x) + prev_tab[i].w - cx;
      dy = 2 * longint'(prev_tab[i].y) + prev_tab[i].h - cy;
      d = dx * dx + dy * dy;
      if (d < best) begin
        best = d;
        hit = 1;
        idx = i;
      end
    end
    c = 0;
    if (hit) begin
      cap = confirm_at + 1;
      if (cap > 63) cap = 63;
      c = prev_tab[idx].cnt;
      c = (c >= cap) ? cap : c + 1;
    end
    v.cnt = c[5:0];
    if (cur_fill < 64) begin
      cur_tab[cur_fill] = '{x: x, y: y, w: w, h: h, cnt: v.cnt};
      cur_fill++;
      v.status = (v.cnt == confirm_at) ? ST_CONFIRM : ST_TRACK;
    end else begin
      v.status = ST_FULL;
    end
    return v;
  endfunction

  assign pending = exp_q.size();

  always @(posedge clk) begin
    verdict_t e;
    if (!rst_n) begin
      lim_min_w <= 10; lim_max_w <= 150; lim_min_h <= 10; lim_max_h <= 150;
      radius <= 50; confirm_at <= 5;
      prev_fill = 0; cur_fill = 0;
      exp_q.delete();
      fail_count <= 0; results_seen <= 0; confirms_seen <= 0; full_seen <= 0;
    end else begin
      // compare a result first: it belongs to an earlier request
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (out_status == ST_CONFIRM) confirms_seen <= confirms_seen + 1;
        if (out_status == ST_FULL) full_seen <= full_seen + 1;
        if (exp_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = exp_q.pop_front();
          if (out_status !== e.status || out_track_count !== e.cnt ||
              out_x !== e.x || out_y !== e.y || out_w !== e.w || out_h !== e.h) begin
            fail_count <= fail_count + 1;
            if (out_status !== e.status)
              $error("status exp %0d got %0d", e.status, out_status);
            if (out_track_count !== e.cnt)
              $error("track_count exp %0d got %0d", e.cnt, out_track_count);
            if (out_x !== e.x) $error("out_x exp %0d got %0d", e.x, out_x);
            if (out_y !== e.y) $error("out_y exp %0d got %0d", e.y, out_y);
            if (out_w !== e.w) $error("out_w exp %0d got %0d", e.w, out_w);
            if (out_h !== e.h) $error("out_h exp %0d got %0d", e.h, out_h);
          end
        end
      end
      // accepted request
      if (start && !busy) begin
        if (in_func == FN_EOF) begin
          prev_tab = cur_tab;
          prev_fill = cur_fill;
          cur_fill = 0;
        end else begin
          exp_q = {exp_q, track_box(in_box_x, in_box_y, in_box_w, in_box_h)};
        end
      end
      // register write
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_MIN_W:   lim_min_w  <= pwdata[11:0];
          REG_MAX_W:   lim_max_w  <= pwdata[11:0];
          REG_MIN_H:   lim_min_h  <= pwdata[11:0];
          REG_MAX_H:   lim_max_h  <= pwdata[11:0];
          REG_RADIUS:  radius     <= pwdata[11:0];
          REG_CONFIRM: confirm_at <= pwdata[5:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* test/tb_detection_track_confirm.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_detection_track_confirm
// drives box and end-of-frame requests and register writes into the track
// confirmation block; frames of boxes jittered around a set of moving tracks
// build up hit counts, while noise boxes, size extremes and full tables hit
// the corner cases; a checker module predicts and compares every result
// ----------------------------------------------------------------------------
module tb_detection_track_confirm;
  import dtc_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_func = FN_BOX;
  logic [11:0] in_box_x = 0, in_box_y = 0, in_box_w = 0, in_box_h = 0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_track_count;
  logic [11:0] out_x, out_y, out_w, out_h;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, results_seen, confirms_seen, full_seen;
  int          cycles = 0;
  int          idle_pct = 8;
  int          requests = 0;

  always #2 clk = ~clk;

  detection_track_confirm dut (.*);

  dtc_checker chk (.*);

  // run limit: ~2000 items plus gaps, many times over
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("tb_detection_track_confirm: FAIL");
      $finish;
    end
  end

  // one request, with a random gap before it in the sender's idle share;
  // start stays high after the accept until the next gap or drain
  task automatic send(logic fn, logic [11:0] x, y, w, h);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; in_func <= fn;
    in_box_x <= x; in_box_y <= y; in_box_w <= w; in_box_h <= h;
    do @(posedge clk); while (busy);
    requests++;
  endtask

  task automatic box(int x, y, w, h);
    send(FN_BOX, 12'(x), 12'(y), 12'(w), 12'(h));
  endtask

  task automatic end_frame();
    send(FN_EOF, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // wait until all results are in, plus the block's latency
  task automatic drain();
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic set_limits(int mnw, mxw, mnh, mxh, rad, conf);
    drain();
    reg_write(REG_MIN_W, mnw);
    reg_write(REG_MAX_W, mxw);
    reg_write(REG_MIN_H, mnh);
    reg_write(REG_MAX_H, mxh);
    reg_write(REG_RADIUS, rad);
    reg_write(REG_CONFIRM, conf);
  endtask

  // frames of jittered boxes around moving tracks plus some noise
  task automatic track_frames(int nframes, int ntracks, int jit, int sz);
    int tx [16], ty [16], tw [16], th [16];
    for (int t = 0; t < ntracks; t++) begin
      tx[t] = $urandom_range(3000); ty[t] = $urandom_range(3000);
      tw[t] = $urandom_range(sz, 10); th[t] = $urandom_range(sz, 10);
    end
    for (int f = 0; f < nframes; f++) begin
      for (int t = 0; t < ntracks; t++) begin
        if ($urandom_range(9) != 0)
          box(tx[t] + $urandom_range(2 * jit) - jit, ty[t] + $urandom_range(2 * jit) - jit,
              tw[t] + $urandom_range(4) - 2, th[t] + $urandom_range(4) - 2);
        if ($urandom_range(7) == 0)
          box($urandom, $urandom, $urandom_range(sz + 20), $urandom_range(sz + 20));
        tx[t] += $urandom_range(6) - 3;
        ty[t] += $urandom_range(6) - 3;
      end
      if ($urandom_range(15) == 0) box($urandom, $urandom, $urandom, $urandom);
      end_frame();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: size extremes, matching, ties, saturation, full table
    box(0, 0, 0, 0);
    box(12'hfff, 12'hfff, 12'hfff, 12'hfff);
    box(100, 100, 10, 10);
    box(100, 100, 150, 150);
    box(100, 100, 9, 50);
    box(100, 100, 50, 151);
    box(500, 500, 20, 20);
    box(600, 500, 20, 20);
    end_frame();
    box(550, 500, 20, 20);      // equidistant from two, both at the radius, neither matches
    box(101, 100, 10, 10);
    box(3000, 3000, 40, 40);    // no match
    end_frame();
    for (int f = 0; f < 8; f++) begin
      box(551, 500, 20, 20);
      end_frame();
    end
    set_limits(0, 12'hfff, 0, 12'hfff, 12'hfff, 63);
    for (int f = 0; f < 66; f++) begin
      box(2000, 2000, 30, 30);
      end_frame();
    end
    set_limits(0, 12'hfff, 0, 12'hfff, 12'hfff, 2);  // count above cap
    box(2000, 2000, 30, 30);
    for (int i = 0; i < 66; i++) box($urandom, $urandom, $urandom, $urandom);
    end_frame();
    box(0, 0, 0, 0);
    end_frame();
    set_limits(0, 0, 0, 0, 0, 0);
    box(0, 0, 0, 0);
    box(0, 0, 0, 1);
    end_frame();
    box(0, 0, 0, 0);
    end_frame();

    // random: three idling phases, several register settings
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 8 : (ph == 1) ? 55 : 0;
      set_limits(10, 150, 10, 150, 50, 5);
      track_frames(20, 8, 6, 120);
      set_limits($urandom_range(20), $urandom_range(4095, 200), $urandom_range(20),
                 $urandom_range(4095, 200), $urandom_range(200, 20), $urandom_range(6, 1));
      track_frames(15, 10, 15, 180);
      set_limits(5, 60, 5, 60, 4095, 3);
      track_frames(8, 14, 30, 50);
      set_limits(0, 4095, 0, 4095, 1, 62);
      track_frames(8, 6, 0, 40);
    end

    drain();
    $display("ran %0d requests, %0d results checked: %0d confirmations, %0d table-full drops",
             requests, results_seen, confirms_seen, full_seen);
    if (fail_count == 0) begin
      $display("tb_detection_track_confirm: PASS");
    end else begin
      $display("tb_detection_track_confirm: FAIL");
    end
    $finish;
  end

endmodule
